// ===== rtl/ssd_pkg.sv =====
// shared constants, digit tables and reciprocal constants for the scan display driver
package ssd_pkg;

	localparam int NUM_DIGITS = 8;

	localparam int POS_W = 3;
	localparam int CNT_W = 4;

	localparam logic OP_BUTTON = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [4:0] MODE_BINARY  = 5'h01;
	localparam logic [4:0] MODE_HEX     = 5'h02;
	localparam logic [4:0] MODE_DECIMAL = 5'h10;

	localparam logic [CNT_W-1:0] COUNT_BINARY  = CNT_W'(NUM_DIGITS);
	localparam logic [CNT_W-1:0] COUNT_HEX     = CNT_W'(4);
	localparam logic [CNT_W-1:0] COUNT_DECIMAL = CNT_W'(5);

	localparam logic [7:0] SEG_BLANK    = 8'hff;
	localparam logic [7:0] SELECT_RIGHT = 8'hfe;

	typedef logic [7:0] seg_t;

	// active-low glyphs for 0..f
	function automatic seg_t glyph(input logic [3:0] d);
		seg_t g;
		case (d)
			4'h0: g = 8'hc0;
			4'h1: g = 8'hf9;
			4'h2: g = 8'ha4;
			4'h3: g = 8'hb0;
			4'h4: g = 8'h99;
			4'h5: g = 8'h92;
			4'h6: g = 8'h82;
			4'h7: g = 8'hf8;
			4'h8: g = 8'h80;
			4'h9: g = 8'h90;
			4'ha: g = 8'h88;
			4'hb: g = 8'h83;
			4'hc: g = 8'hc6;
			4'hd: g = 8'ha1;
			4'he: g = 8'h86;
			4'hf: g = 8'h8e;
			default: g = SEG_BLANK;
		endcase
		return g;
	endfunction

	// ceil(2^32 / 10^k), exact floor quotient for any 16-bit value
	function automatic logic [31:0] recip_pow10(input logic [POS_W-1:0] k);
		logic [31:0] r;
		case (k)
			3'd1: r = 32'd429496730;
			3'd2: r = 32'd42949673;
			3'd3: r = 32'd4294968;
			3'd4: r = 32'd429497;
			3'd5: r = 32'd42950;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/seven_segment_scan_display.sv =====
// top level of the multiplexed seven-segment scan display driver
//
// Each request passes an input register, and a scan tick then goes through the digit logic
// into the result register. A new request is taken every cycle while request_stall is low.
// Button events give no result and never wait on the result side. The longest path is
// the decimal digit pick: two parallel 16 by 32 reciprocal multiplies followed by a
// short subtract and the glyph lookup. request_stall rises only while a tick sits in
// the input register and the result register is full and stalled.
module seven_segment_scan_display import ssd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        request_valid,
	output logic        request_stall,
	input  logic        operation,
	input  logic [15:0] switch_value,
	input  logic [4:0]  button_code,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  digit_select,
	output logic [7:0]  segment_code
);

	logic             valid_s1;
	logic             op_s1;
	logic [15:0]      switch_s1;
	logic [4:0]       button_s1;

	logic [15:0]      held_q;
	logic [4:0]       mode_q;
	logic [POS_W-1:0] pos_q;

	logic             result_valid_q;
	logic [7:0]       select_q;
	seg_t             segment_q;

	logic             fire_s1;
	logic             load_s1;
	logic             tick_fire;

	logic             mode_known;
	logic [CNT_W-1:0] count;
	logic [CNT_W-1:0] pos_inc;
	logic [POS_W-1:0] pos_next;
	logic [3:0]       digit;
	logic [7:0]       select_d;
	seg_t             segment_d;

	logic [POS_W-1:0] pos_up;
	logic [47:0]      prod_lo;
	logic [47:0]      prod_hi;
	logic [15:0]      quot_lo;
	logic [15:0]      quot_hi;
	logic [15:0]      dec_diff;
	logic [3:0]       dec_digit;
	logic [3:0]       hex_digit;

	assign fire_s1   = valid_s1 && (op_s1 == OP_BUTTON || !result_valid_q || !result_stall);
	assign load_s1   = !valid_s1 || fire_s1;
	assign tick_fire = fire_s1 && op_s1 == OP_TICK;

	assign request_stall = !load_s1;

	// decimal digit as floor(v / 10^p) - 10 * floor(v / 10^(p+1))
	assign pos_up   = pos_q + POS_W'(1);
	assign prod_lo  = 48'(held_q) * 48'(recip_pow10(pos_q));
	assign prod_hi  = 48'(held_q) * 48'(recip_pow10(pos_up));
	assign quot_lo  = (pos_q == '0) ? held_q : prod_lo[47:32];
	assign quot_hi  = prod_hi[47:32];
	assign dec_diff = quot_lo - (quot_hi << 3) - (quot_hi << 1);

	always_comb begin
		if (pos_q < POS_W'(5)) begin
			dec_digit = dec_diff[3:0];
		end else begin
			dec_digit = 4'd0;
		end
		case (pos_q)
			3'd0: hex_digit = held_q[3:0];
			3'd1: hex_digit = held_q[7:4];
			3'd2: hex_digit = held_q[11:8];
			3'd3: hex_digit = held_q[15:12];
			default: hex_digit = 4'd0;
		endcase
	end

	always_comb begin
		mode_known = 1'b1;
		count      = COUNT_DECIMAL;
		digit      = dec_digit;
		case (mode_q)
			MODE_BINARY: begin
				count = COUNT_BINARY;
				digit = {3'd0, held_q[pos_q]};
			end
			MODE_HEX: begin
				count = COUNT_HEX;
				digit = hex_digit;
			end
			MODE_DECIMAL: begin
				count = COUNT_DECIMAL;
				digit = dec_digit;
			end
			default: begin
				mode_known = 1'b0;
			end
		endcase

		pos_inc = CNT_W'(pos_q) + CNT_W'(1);
		if (pos_inc >= count) begin
			pos_next = '0;
		end else begin
			pos_next = pos_inc[POS_W-1:0];
		end

		if (mode_known) begin
			select_d  = ~(8'd1 << pos_q);
			segment_d = glyph(digit);
		end else begin
			select_d  = SELECT_RIGHT;
			segment_d = SEG_BLANK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			held_q         <= '0;
			mode_q         <= '0;
			pos_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= request_valid;
			end
			if (fire_s1 && op_s1 == OP_BUTTON) begin
				held_q <= switch_s1;
				if (button_s1 != 5'd0) begin
					mode_q <= button_s1;
				end
			end
			if (tick_fire && mode_known) begin
				pos_q <= pos_next;
			end
			if (tick_fire) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && request_valid) begin
			op_s1     <= operation;
			switch_s1 <= switch_value;
			button_s1 <= button_code;
		end
		if (tick_fire) begin
			select_q  <= select_d;
			segment_q <= segment_d;
		end
	end

	assign result_valid = result_valid_q;
	assign digit_select = select_q;
	assign segment_code = segment_q;

	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick_fire |=> result_valid)
		else $error("scan tick gave no result");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(pos_q) < COUNT_BINARY)
		else $error("scan position beyond digit count");

	a_hex_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_fire && mode_q == MODE_HEX) |=> pos_q < POS_W'(4))
		else $error("hex scan did not wrap");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		request_stall |-> (valid_s1 && op_s1 == OP_TICK && result_valid_q && result_stall))
		else $error("request stalled without a full result register");

	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $countones(~digit_select) == 1)
		else $error("result drives other than one digit");

endmodule

// ===== test/tb_seven_segment_scan_display.sv =====
// self-checking testbench for the seven-segment scan display driver
module tb_seven_segment_scan_display;
	import ssd_pkg::*;

	typedef struct packed {
		logic        operation;
		logic [15:0] switch_value;
		logic [4:0]  button_code;
	} scan_req_t;

	typedef struct packed {
		logic [7:0] digit_select;
		logic [7:0] segment_code;
	} digit_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        request_valid = 1'b0;
	logic        request_stall;
	logic        operation = OP_BUTTON;
	logic [15:0] switch_value = 16'h0000;
	logic [4:0]  button_code = 5'h00;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [7:0]  digit_select;
	logic [7:0]  segment_code;

	scan_req_t  pending_requests[$];
	digit_out_t expected_digits[$];
	scan_req_t  cur_req;
	logic [7:0] glyph_rom [16];
	logic [15:0] stored_switches = 16'h0000;
	logic [4:0]  shown_mode = 5'h00;
	logic [2:0]  scan_idx = 3'd0;
	int          mismatches = 0;
	int          gap_left = 0;
	logic        calm = 1'b0;

	seven_segment_scan_display uut (
		.clk(clk),
		.arst_n(arst_n),
		.request_valid(request_valid),
		.request_stall(request_stall),
		.operation(operation),
		.switch_value(switch_value),
		.button_code(button_code),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.digit_select(digit_select),
		.segment_code(segment_code)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		mismatches++;
	endtask

	task automatic add_request(input logic op, input logic [15:0] sw, input logic [4:0] btn);
		scan_req_t r;
		r.operation = op;
		r.switch_value = sw;
		r.button_code = btn;
		pending_requests.push_back(r);
	endtask

	task automatic predict_scan(input scan_req_t r);
		digit_out_t e;
		logic [3:0] d;
		int count;
		int v;
		int n;
		int nxt;
		if (r.operation == OP_BUTTON) begin
			stored_switches = r.switch_value;
			if (r.button_code != 5'h00)
				shown_mode = r.button_code;
			return;
		end
		if (shown_mode != MODE_BINARY && shown_mode != MODE_HEX && shown_mode != MODE_DECIMAL) begin
			e.digit_select = SELECT_RIGHT;
			e.segment_code = SEG_BLANK;
			expected_digits.push_back(e);
			return;
		end
		case (shown_mode)
			MODE_BINARY: begin
				d = {3'b000, stored_switches[scan_idx]};
				count = NUM_DIGITS;
			end
			MODE_HEX: begin
				d = (scan_idx < 3'd4) ? stored_switches[4*scan_idx +: 4] : 4'h0;
				count = 4;
			end
			default: begin
				v = stored_switches;
				for (n = 0; n < scan_idx; n++)
					v = v / 10;
				d = 4'(v % 10);
				count = 5;
			end
		endcase
		e.digit_select = ~(8'h01 << scan_idx);
		e.segment_code = glyph_rom[d];
		expected_digits.push_back(e);
		nxt = scan_idx + 1;
		scan_idx = (nxt >= count) ? 3'd0 : 3'(nxt);
	endtask

	always @(posedge clk) begin : driver
		logic taken;
		taken = request_valid && !request_stall;
		if (!arst_n) begin
			request_valid <= 1'b0;
		end else begin
			if (taken)
				predict_scan(cur_req);
			if (request_valid && !taken) begin
			end else if (gap_left > 0) begin
				gap_left--;
				request_valid <= 1'b0;
			end else if (pending_requests.size() == 0) begin
				request_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				gap_left = $urandom_range(0, 13);
				request_valid <= 1'b0;
			end else begin
				cur_req = pending_requests.pop_front();
				request_valid <= 1'b1;
				operation <= cur_req.operation;
				switch_value <= cur_req.switch_value;
				button_code <= cur_req.button_code;
			end
			calm <= pending_requests.size() < 80;
		end
	end

	always @(posedge clk) begin : receiver
		int stall_left;
		int hold_left;
		int cycles;
		logic hold_done;
		if (!arst_n) begin
			stall_left = 0;
			hold_left = 0;
			cycles = 0;
			hold_done = 1'b0;
			result_stall <= 1'b0;
		end else begin
			cycles++;
			// one long hold-off so the pipeline fills and backs up
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (!hold_done && cycles >= 250) begin
				hold_done = 1'b1;
				hold_left = 80;
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 13);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		digit_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_digits.size() == 0) begin
				report_mismatch("unexpected digit", digit_select, segment_code);
			end else begin
				want = expected_digits.pop_front();
				if (digit_select !== want.digit_select)
					report_mismatch("digit_select", digit_select, want.digit_select);
				if (segment_code !== want.segment_code)
					report_mismatch("segment_code", segment_code, want.segment_code);
			end
		end
	end

	initial begin : stimulus
		int i;
		int k;
		int r;
		logic [15:0] sw;
		logic [4:0] btn;
		glyph_rom[0] = 8'hc0;
		glyph_rom[1] = 8'hf9;
		glyph_rom[2] = 8'ha4;
		glyph_rom[3] = 8'hb0;
		glyph_rom[4] = 8'h99;
		glyph_rom[5] = 8'h92;
		glyph_rom[6] = 8'h82;
		glyph_rom[7] = 8'hf8;
		glyph_rom[8] = 8'h80;
		glyph_rom[9] = 8'h90;
		glyph_rom[10] = 8'h88;
		glyph_rom[11] = 8'h83;
		glyph_rom[12] = 8'hc6;
		glyph_rom[13] = 8'ha1;
		glyph_rom[14] = 8'h86;
		glyph_rom[15] = 8'h8e;

		// blank after reset, released button keeps the blank mode
		add_request(OP_TICK, 16'h0000, 5'h00);
		add_request(OP_BUTTON, 16'hffff, 5'h00);
		add_request(OP_TICK, 16'h0000, 5'h00);
		add_request(OP_BUTTON, 16'hffff, MODE_BINARY);
		for (i = 0; i < 7; i++)
			add_request(OP_TICK, 16'h0000, 5'h00);
		// leftover position seven in decimal mode
		add_request(OP_BUTTON, 16'hffff, MODE_DECIMAL);
		add_request(OP_TICK, 16'h0000, 5'h00);
		add_request(OP_TICK, 16'h0000, 5'h00);
		add_request(OP_BUTTON, 16'ha5f3, MODE_HEX);
		for (i = 0; i < 4; i++)
			add_request(OP_TICK, 16'h0000, 5'h00);
		add_request(OP_BUTTON, 16'h0000, 5'h1f);
		add_request(OP_TICK, 16'h0000, 5'h00);
		add_request(OP_BUTTON, 16'h0000, MODE_DECIMAL);
		add_request(OP_TICK, 16'h0000, 5'h00);
		add_request(OP_BUTTON, 16'h3039, 5'h03);
		add_request(OP_TICK, 16'hffff, 5'h1f);

		for (i = 0; i < 525; i++) begin
			k = $urandom_range(0, 99);
			if (k < 22) begin
				r = $urandom_range(0, 11);
				if (r < 3)
					btn = MODE_BINARY;
				else if (r < 6)
					btn = MODE_HEX;
				else if (r < 9)
					btn = MODE_DECIMAL;
				else if (r == 9)
					btn = 5'h00;
				else
					btn = 5'($urandom);
				r = $urandom_range(0, 7);
				if (r == 0)
					sw = 16'h0000;
				else if (r == 1)
					sw = 16'hffff;
				else
					sw = 16'($urandom);
				add_request(OP_BUTTON, sw, btn);
			end else begin
				add_request(OP_TICK, 16'($urandom), 5'($urandom));
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (pending_requests.size() != 0 || request_valid || expected_digits.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0 && expected_digits.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#400000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
